// ===== src/jfdd_pkg.sv =====
// Package for the joystick frame differential drive block.
// Holds the word types, register indexes, reset values and shared constants.
// No dependencies; jfdd_seq and the top level use it.
package jfdd_pkg;

  localparam int unsigned APB_ADDR_W = 4;
  localparam int unsigned APB_DATA_W = 32;

  localparam logic [1:0] REG_DEADBAND = 2'd0;
  localparam logic [1:0] REG_PERIOD   = 2'd1;
  localparam logic [1:0] REG_CENTRE   = 2'd2;
  localparam logic [1:0] REG_TIMEOUT  = 2'd3;

  localparam logic [6:0]  DEADBAND_RST = 7'd26;
  localparam logic [15:0] PERIOD_RST   = 16'd4200;
  localparam logic [9:0]  CENTRE_RST   = 10'd127;
  localparam logic [15:0] TIMEOUT_RST  = 16'd1000;

  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;

  localparam logic REQ_BYTE = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  typedef struct packed {
    logic       req_type;
    logic [7:0] rx_byte;
  } in_word_t;

  typedef struct packed {
    logic [15:0] left_duty;
    logic [15:0] right_duty;
    logic        left_forward;
    logic        left_reverse;
    logic        right_forward;
    logic        right_reverse;
    logic        was_timeout;
  } out_word_t;

  typedef struct packed {
    logic busy;
    logic done;
  } seq_stat_t;

endpackage

// ===== src/jfdd_mac.sv =====
// Shared multiply-add unit of the joystick frame differential drive block.
// Computes a signed operand times an unsigned operand plus a small addend into
// a result register. Depends on nothing.
module jfdd_mac #(
  parameter int unsigned AW = 24,
  parameter int unsigned BW = 16
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [AW-1:0] a_i,
  input  logic [BW-1:0]        b_i,
  input  logic [3:0]           c_i,
  output logic [AW+BW-1:0]     res_o
);

  localparam int unsigned RW = AW + BW;

  logic signed [RW:0] prod;
  logic signed [RW:0] sum;
  logic [RW-1:0]      res_q;
  logic [RW-1:0]      res_d;

  assign prod  = a_i * $signed({1'b0, b_i});
  assign sum   = prod + $signed({{(RW - 3){1'b0}}, c_i});
  assign res_d = sum[RW-1:0];
  assign res_o = res_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
    end
  end

endmodule

// ===== src/jfdd_seq.sv =====
// Sequencer of the joystick frame differential drive block.
// Parses one stored frame, mixes and scales it on the shared unit jfdd_mac.
// Depends on jfdd_pkg and jfdd_mac.
module jfdd_seq #(
  parameter int unsigned FRAME_LEN = 6
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic                         slot_free_i,
  input  logic [6:0]                   deadband_i,
  input  logic [15:0]                  period_i,
  input  logic [9:0]                   centre_i,
  output logic [$clog2(FRAME_LEN)-1:0] rd_idx_o,
  input  logic [7:0]                   rd_byte_i,
  output jfdd_pkg::seq_stat_t          stat_o,
  output jfdd_pkg::out_word_t          word_o
);

  localparam int unsigned IDX_W  = $clog2(FRAME_LEN);
  localparam int unsigned HALF   = FRAME_LEN / 2;
  localparam int unsigned DIG    = FRAME_LEN - HALF;
  localparam int unsigned NUM_W  = $clog2(10 ** DIG);
  localparam int unsigned XM_W   = (NUM_W > 10) ? NUM_W : 10;
  localparam int unsigned X_W    = XM_W + 1;
  localparam int unsigned T_W    = X_W + XM_W;
  localparam int unsigned Q_W    = T_W - 7;
  localparam int unsigned MIX_W  = ((X_W + 1 > Q_W) ? X_W + 1 : Q_W) + 1;
  localparam int unsigned AW     = MIX_W + 1;
  localparam int unsigned BW     = (XM_W > 16) ? XM_W : 16;
  localparam int unsigned RW     = AW + BW;

  typedef enum logic [3:0] {
    S_IDLE, S_PARSE_X, S_SAVE_X, S_PARSE_Y, S_SAVE_Y,
    S_MUL_Q, S_MIX, S_DUTY_L, S_DUTY_R, S_FIN
  } state_e;

  state_e                   state_q, state_d;
  logic [IDX_W-1:0]         k_q, k_d;
  logic                     stop_q, stop_d;
  logic signed [X_W-1:0]    x_q, x_d, y_q, y_d;
  logic signed [MIX_W-1:0]  lm_q, lm_d, rm_q, rm_d;
  logic [15:0]              dl_q, dl_d;

  logic                     mac_en;
  logic signed [AW-1:0]     mac_a;
  logic [BW-1:0]            mac_b;
  logic [3:0]               mac_c;
  logic [RW-1:0]            mac_res;

  logic                     is_dig;
  logic [7:0]               dig_byte;
  logic signed [X_W-1:0]    num_val;
  logic [XM_W-1:0]          x_abs;
  logic signed [Q_W-1:0]    q_val;
  logic [MIX_W-1:0]         lm_abs, rm_abs;
  logic [RW-8:0]            scaled;
  logic [15:0]              duty_sat;
  logic signed [MIX_W-1:0]  db_pos, db_neg;

  jfdd_mac #(.AW(AW), .BW(BW)) u_mac (
    .clk_i (clk_i),
    .en_i  (mac_en),
    .a_i   (mac_a),
    .b_i   (mac_b),
    .c_i   (mac_c),
    .res_o (mac_res)
  );

  assign dig_byte = rd_byte_i - jfdd_pkg::CHAR_ZERO;
  assign is_dig   = (rd_byte_i >= jfdd_pkg::CHAR_ZERO) && (rd_byte_i <= jfdd_pkg::CHAR_NINE);
  assign num_val  = $signed({{(X_W - NUM_W){1'b0}}, mac_res[NUM_W-1:0]})
                  - $signed({{(X_W - 10){1'b0}}, centre_i});
  assign x_abs    = x_q[X_W-1] ? XM_W'(-x_q) : x_q[XM_W-1:0];
  assign q_val    = $signed(mac_res[T_W-1:7]);
  assign lm_abs   = lm_q[MIX_W-1] ? -lm_q : lm_q;
  assign rm_abs   = rm_q[MIX_W-1] ? -rm_q : rm_q;
  assign scaled   = mac_res[RW-1:7];
  assign duty_sat = (scaled > {{(RW - 23){1'b0}}, period_i}) ? period_i : scaled[15:0];
  assign db_pos   = $signed({{(MIX_W - 7){1'b0}}, deadband_i});
  assign db_neg   = -db_pos;

  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    stop_d  = stop_q;
    x_d     = x_q;
    y_d     = y_q;
    lm_d    = lm_q;
    rm_d    = rm_q;
    dl_d    = dl_q;
    mac_en  = 1'b0;
    mac_a   = '0;
    mac_b   = '0;
    mac_c   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          mac_en  = 1'b1;
          k_d     = '0;
          stop_d  = 1'b0;
          state_d = S_PARSE_X;
        end
      end
      S_PARSE_X, S_PARSE_Y: begin
        if (is_dig && !stop_q) begin
          mac_en = 1'b1;
          mac_a  = $signed({{(AW - NUM_W){1'b0}}, mac_res[NUM_W-1:0]});
          mac_b  = BW'(10);
          mac_c  = dig_byte[3:0];
        end else begin
          stop_d = 1'b1;
        end
        k_d = k_q + 1'b1;
        if (state_q == S_PARSE_X && k_q == IDX_W'(HALF - 1)) begin
          state_d = S_SAVE_X;
        end else if (state_q == S_PARSE_Y && k_q == IDX_W'(FRAME_LEN - 1)) begin
          state_d = S_SAVE_Y;
        end
      end
      S_SAVE_X: begin
        mac_en  = 1'b1;
        stop_d  = 1'b0;
        x_d     = num_val;
        state_d = S_PARSE_Y;
      end
      S_SAVE_Y: begin
        y_d     = num_val;
        state_d = S_MUL_Q;
      end
      S_MUL_Q: begin
        mac_en  = 1'b1;
        mac_a   = $signed({{(AW - X_W){y_q[X_W-1]}}, y_q});
        mac_b   = {{(BW - XM_W){1'b0}}, x_abs};
        state_d = S_MIX;
      end
      S_MIX: begin
        lm_d = $signed({{(MIX_W - X_W){x_q[X_W-1]}}, x_q})
             + $signed({{(MIX_W - X_W){y_q[X_W-1]}}, y_q})
             - $signed({{(MIX_W - Q_W){q_val[Q_W-1]}}, q_val});
        rm_d = $signed({{(MIX_W - X_W){x_q[X_W-1]}}, x_q})
             - $signed({{(MIX_W - X_W){y_q[X_W-1]}}, y_q})
             + $signed({{(MIX_W - Q_W){q_val[Q_W-1]}}, q_val});
        state_d = S_DUTY_L;
      end
      S_DUTY_L: begin
        mac_en  = 1'b1;
        mac_a   = $signed({1'b0, lm_abs});
        mac_b   = {{(BW - 16){1'b0}}, period_i};
        state_d = S_DUTY_R;
      end
      S_DUTY_R: begin
        mac_en  = 1'b1;
        mac_a   = $signed({1'b0, rm_abs});
        mac_b   = {{(BW - 16){1'b0}}, period_i};
        dl_d    = duty_sat;
        state_d = S_FIN;
      end
      S_FIN: begin
        if (slot_free_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      k_q     <= '0;
      stop_q  <= 1'b0;
      x_q     <= '0;
      y_q     <= '0;
      lm_q    <= '0;
      rm_q    <= '0;
      dl_q    <= '0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      stop_q  <= stop_d;
      x_q     <= x_d;
      y_q     <= y_d;
      lm_q    <= lm_d;
      rm_q    <= rm_d;
      dl_q    <= dl_d;
    end
  end

  assign rd_idx_o    = k_q;
  assign stat_o.busy = (state_q != S_IDLE);
  assign stat_o.done = (state_q == S_FIN) && slot_free_i;

  assign word_o.left_duty     = dl_q;
  assign word_o.right_duty    = duty_sat;
  assign word_o.left_forward  = (lm_q > db_pos);
  assign word_o.left_reverse  = (lm_q < db_neg);
  assign word_o.right_forward = (rm_q > db_pos);
  assign word_o.right_reverse = (rm_q < db_neg);
  assign word_o.was_timeout   = 1'b0;

endmodule

// ===== src/joystick_frame_differential_drive_top.sv =====
// Top level of the joystick frame differential drive block.
// Holds the register port, frame store, watchdog and output register.
// Depends on jfdd_pkg and jfdd_seq.

// The byte that completes a frame starts the sequencer, which keeps the input
// stalled while it parses and scales the frame and until the finished word can
// enter the output register; one shared multiply-add unit parses one digit per
// cycle and then forms the steering product and both duties. A timer tick is
// stalled while the output register is full and held. A word can wait at the
// output while the next byte is accepted.
module joystick_frame_differential_drive_top #(
  parameter int unsigned FRAME_LEN = 6
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  jfdd_pkg::in_word_t                  in_word_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output jfdd_pkg::out_word_t                 out_word_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [jfdd_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [jfdd_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [jfdd_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready
);

  localparam int unsigned IDX_W = $clog2(FRAME_LEN);

  logic [6:0]          deadband_q;
  logic [15:0]         pwm_period_q;
  logic [9:0]          centre_q;
  logic [15:0]         timeout_q;

  logic [7:0]          store_q [FRAME_LEN];
  logic [IDX_W-1:0]    byte_idx_q, byte_idx_d;
  logic [15:0]         idle_ticks_q, idle_ticks_d;
  logic                out_valid_q, out_valid_d;
  jfdd_pkg::out_word_t out_word_q, out_word_d;

  logic                in_acc, out_acc, cfg_wr;
  logic                is_tick, is_byte, frame_done, wd_fire;
  logic [15:0]         idle_inc;
  logic                slot_free;
  logic [IDX_W-1:0]    rd_idx;
  jfdd_pkg::seq_stat_t seq_stat;
  jfdd_pkg::out_word_t seq_word;
  jfdd_pkg::out_word_t stop_word;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    unique case (paddr[3:2])
      jfdd_pkg::REG_DEADBAND: prdata = {25'd0, deadband_q};
      jfdd_pkg::REG_PERIOD:   prdata = {16'd0, pwm_period_q};
      jfdd_pkg::REG_CENTRE:   prdata = {22'd0, centre_q};
      jfdd_pkg::REG_TIMEOUT:  prdata = {16'd0, timeout_q};
      default:                prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deadband_q   <= jfdd_pkg::DEADBAND_RST;
      pwm_period_q <= jfdd_pkg::PERIOD_RST;
      centre_q     <= jfdd_pkg::CENTRE_RST;
      timeout_q    <= jfdd_pkg::TIMEOUT_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        jfdd_pkg::REG_DEADBAND: deadband_q   <= pwdata[6:0];
        jfdd_pkg::REG_PERIOD:   pwm_period_q <= pwdata[15:0];
        jfdd_pkg::REG_CENTRE:   centre_q     <= pwdata[9:0];
        jfdd_pkg::REG_TIMEOUT:  timeout_q    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  assign slot_free  = !out_valid_q || !out_stall_i;
  assign is_tick    = (in_word_i.req_type == jfdd_pkg::REQ_TICK);
  assign is_byte    = (in_word_i.req_type == jfdd_pkg::REQ_BYTE);
  assign in_stall_o = seq_stat.busy || (out_valid_q && out_stall_i && is_tick);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_acc    = out_valid_q && !out_stall_i;

  assign idle_inc   = idle_ticks_q + 16'd1;
  assign wd_fire    = in_acc && is_tick && ((idle_inc >= timeout_q) || (idle_inc == 16'd0));
  assign frame_done = in_acc && is_byte && (byte_idx_q == IDX_W'(FRAME_LEN - 1));

  assign stop_word = '{left_duty: 16'd0, right_duty: 16'd0, left_forward: 1'b0,
                       left_reverse: 1'b0, right_forward: 1'b0, right_reverse: 1'b0,
                       was_timeout: 1'b1};

  always_comb begin
    byte_idx_d   = byte_idx_q;
    idle_ticks_d = idle_ticks_q;
    out_valid_d  = out_valid_q;
    out_word_d   = out_word_q;
    if (out_acc) begin
      out_valid_d = 1'b0;
    end
    if (in_acc && is_tick) begin
      idle_ticks_d = idle_inc;
      if (wd_fire) begin
        idle_ticks_d = '0;
        byte_idx_d   = '0;
        out_valid_d  = 1'b1;
        out_word_d   = stop_word;
      end
    end else if (in_acc && is_byte) begin
      byte_idx_d = byte_idx_q + 1'b1;
      if (frame_done) begin
        byte_idx_d   = '0;
        idle_ticks_d = '0;
      end
    end
    if (seq_stat.done) begin
      out_valid_d = 1'b1;
      out_word_d  = seq_word;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_idx_q   <= '0;
      idle_ticks_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      byte_idx_q   <= byte_idx_d;
      idle_ticks_q <= idle_ticks_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_word_q <= out_word_d;
    if (in_acc && is_byte) begin
      store_q[byte_idx_q] <= in_word_i.rx_byte;
    end
  end

  jfdd_seq #(.FRAME_LEN(FRAME_LEN)) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (frame_done),
    .slot_free_i (slot_free),
    .deadband_i  (deadband_q),
    .period_i    (pwm_period_q),
    .centre_i    (centre_q),
    .rd_idx_o    (rd_idx),
    .rd_byte_i   (store_q[rd_idx]),
    .stat_o      (seq_stat),
    .word_o      (seq_word)
  );

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  a_duty_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_word_o.was_timeout |->
      out_word_o.left_duty <= pwm_period_q && out_word_o.right_duty <= pwm_period_q)
    else $error("Frame word carries a duty above the period.");

  a_stop_word_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.was_timeout |->
      out_word_o.left_duty == 16'd0 && out_word_o.right_duty == 16'd0 &&
      !out_word_o.left_forward && !out_word_o.left_reverse &&
      !out_word_o.right_forward && !out_word_o.right_reverse)
    else $error("Watchdog stop word drives a motor.");

  a_direction_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_word_o.left_forward && out_word_o.left_reverse) &&
                    !(out_word_o.right_forward && out_word_o.right_reverse))
    else $error("Forward and reverse are set together.");

  a_frame_clears_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(seq_stat.busy) |-> byte_idx_q == '0 && idle_ticks_q == 16'd0)
    else $error("Byte count or watchdog not cleared when a frame started.");

endmodule

// ===== test/joystick_frame_differential_drive_top_test.sv =====
// Testbench for joystick_frame_differential_drive_top: directed frames, then random byte and
// tick streams under several register settings, each drive word checked against a listed word or a predictor.
// Depends on jfdd_pkg and the block's RTL only.
module joystick_frame_differential_drive_top_test;

  localparam int FRAME_LEN     = 6;
  localparam int HALF          = FRAME_LEN / 2;
  localparam int SETTLE_CYCLES = 24;
  localparam int HOLD_CYCLES   = 400;
  localparam int QUIET_LIMIT   = 4000;
  localparam int MIX_WORDS     = 255;

  typedef struct packed {
    logic                typed;
    jfdd_pkg::in_word_t  word;
    jfdd_pkg::out_word_t drive;
  } dir_row_t;

  localparam jfdd_pkg::out_word_t NONE     = '0;
  localparam jfdd_pkg::out_word_t CENTRED  = {16'd0, 16'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0};
  localparam jfdd_pkg::out_word_t FULL_ARC = {16'd4200, 16'd4200, 1'b0, 1'b1, 1'b1, 1'b0,
                                              1'b0};
  localparam jfdd_pkg::out_word_t BACKWARD = {16'd4167, 16'd4167, 1'b0, 1'b1, 1'b0, 1'b1,
                                              1'b0};

  localparam dir_row_t DIR_ROWS [25] = '{
    {1'b0, jfdd_pkg::REQ_BYTE, "1", NONE},
    {1'b0, jfdd_pkg::REQ_BYTE, "2", NONE},
    {1'b0, jfdd_pkg::REQ_BYTE, "7", NONE},
    {1'b0, jfdd_pkg::REQ_BYTE, "1", NONE},
    {1'b0, jfdd_pkg::REQ_BYTE, "2", NONE},
    {1'b1, jfdd_pkg::REQ_BYTE, "7", CENTRED},
    {1'b0, jfdd_pkg::REQ_BYTE, "9", NONE},
    {1'b0, jfdd_pkg::REQ_BYTE, "9", NONE},
    {1'b0, jfdd_pkg::REQ_BYTE, "9", NONE},
    {1'b0, jfdd_pkg::REQ_BYTE, "9", NONE},
    {1'b0, jfdd_pkg::REQ_BYTE, "9", NONE},
    {1'b1, jfdd_pkg::REQ_BYTE, "9", FULL_ARC},
    {1'b0, jfdd_pkg::REQ_BYTE, "5", NONE},
    {1'b0, jfdd_pkg::REQ_BYTE, "/", NONE},
    {1'b0, jfdd_pkg::REQ_BYTE, "7", NONE},
    {1'b0, jfdd_pkg::REQ_BYTE, "2", NONE},
    {1'b0, jfdd_pkg::REQ_BYTE, ":", NONE},
    {1'b0, jfdd_pkg::REQ_BYTE, "3", NONE},
    {1'b0, jfdd_pkg::REQ_TICK, 8'hA5, NONE},
    {1'b0, jfdd_pkg::REQ_BYTE, 8'hFF, NONE},
    {1'b0, jfdd_pkg::REQ_BYTE, "1", NONE},
    {1'b0, jfdd_pkg::REQ_BYTE, "2", NONE},
    {1'b0, jfdd_pkg::REQ_BYTE, 8'h00, NONE},
    {1'b0, jfdd_pkg::REQ_BYTE, "9", NONE},
    {1'b1, jfdd_pkg::REQ_BYTE, "9", BACKWARD}
  };

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  jfdd_pkg::in_word_t  in_word_i;
  logic                out_valid_o;
  logic                out_stall_i;
  jfdd_pkg::out_word_t out_word_o;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [jfdd_pkg::APB_ADDR_W-1:0] paddr;
  logic [jfdd_pkg::APB_DATA_W-1:0] pwdata;
  logic [jfdd_pkg::APB_DATA_W-1:0] prdata;
  logic                pready;

  logic [6:0]  m_deadband;
  logic [15:0] m_period;
  logic [9:0]  m_centre;
  logic [15:0] m_timeout;
  logic [2:0]  m_index;
  logic [7:0]  m_store [8];
  logic [15:0] m_idle;

  jfdd_pkg::out_word_t pending_drive [$];
  logic                in_typed;
  jfdd_pkg::out_word_t in_typed_word;
  logic        hold_req;
  int unsigned errors;
  int unsigned frame_results;
  int unsigned stop_results;
  int unsigned words_sent;
  int unsigned burst_left;
  int unsigned settings_run;
  int unsigned quiet_cycles;

  joystick_frame_differential_drive_top #(.FRAME_LEN(FRAME_LEN)) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic longint decimal_at(input int start, input int len);
    longint value;
    logic   stop;
    logic [7:0] c;
    value = 0;
    stop  = 1'b0;
    for (int i = 0; i < len; i++) begin
      c = m_store[3'(start + i)];
      if (c < jfdd_pkg::CHAR_ZERO || c > jfdd_pkg::CHAR_NINE) stop = 1'b1;
      if (!stop) value = value * 10 + longint'(c - jfdd_pkg::CHAR_ZERO);
    end
    return value;
  endfunction

  function automatic logic [15:0] duty_from_mix(input longint mix);
    longint mag;
    longint duty;
    mag  = (mix < 0) ? -mix : mix;
    duty = (mag * longint'(m_period)) >>> 7;
    if (duty > longint'(m_period)) duty = longint'(m_period);
    return duty[15:0];
  endfunction

  function automatic logic drive_for_word(input jfdd_pkg::in_word_t w,
                                          output jfdd_pkg::out_word_t r);
    longint x;
    longint y;
    longint q;
    longint lm;
    longint rm;
    longint db;
    r = '0;
    if (w.req_type == jfdd_pkg::REQ_TICK) begin
      m_idle = m_idle + 16'd1;
      if (m_idle >= m_timeout || m_idle == 16'd0) begin
        m_idle        = '0;
        m_index       = '0;
        r.was_timeout = 1'b1;
        return 1'b1;
      end
      return 1'b0;
    end
    m_store[m_index] = w.rx_byte;
    m_index = m_index + 3'd1;
    if (m_index < FRAME_LEN && m_index != 3'd0) return 1'b0;
    m_index = '0;
    m_idle  = '0;
    x  = decimal_at(0, HALF) - longint'(m_centre);
    y  = decimal_at(HALF, FRAME_LEN - HALF) - longint'(m_centre);
    q  = (y * ((x < 0) ? -x : x)) >>> 7;
    lm = x + y - q;
    rm = x - y + q;
    db = longint'(m_deadband);
    r.left_duty     = duty_from_mix(lm);
    r.right_duty    = duty_from_mix(rm);
    r.left_forward  = (lm > db);
    r.left_reverse  = (lm < -db);
    r.right_forward = (rm > db);
    r.right_reverse = (rm < -db);
    return 1'b1;
  endfunction

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin : track_words
    jfdd_pkg::out_word_t predicted;
    jfdd_pkg::out_word_t want;
    logic      has;
    logic      moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (in_valid_i && !in_stall_o) begin
        moved = 1'b1;
        has = drive_for_word(in_word_i, predicted);
        if (in_typed) pending_drive.push_back(in_typed_word);
        else if (has) pending_drive.push_back(predicted);
      end
      if (out_valid_o && !out_stall_i) begin
        moved = 1'b1;
        if (pending_drive.size() == 0) begin
          $display("%0t: unexpected drive word %h", $time, out_word_o);
          errors++;
        end else begin
          want = pending_drive.pop_front();
          check_field("left_duty", want.left_duty, out_word_o.left_duty);
          check_field("right_duty", want.right_duty, out_word_o.right_duty);
          check_field("left_forward", 16'(want.left_forward),
                      16'(out_word_o.left_forward));
          check_field("left_reverse", 16'(want.left_reverse),
                      16'(out_word_o.left_reverse));
          check_field("right_forward", 16'(want.right_forward),
                      16'(out_word_o.right_forward));
          check_field("right_reverse", 16'(want.right_reverse),
                      16'(out_word_o.right_reverse));
          check_field("was_timeout", 16'(want.was_timeout),
                      16'(out_word_o.was_timeout));
          if (want.was_timeout) stop_results++;
          else frame_results++;
        end
      end
      quiet_cycles <= moved ? 0 : quiet_cycles + 1;
    end
  end

  initial begin
    do @(posedge clk_i); while (quiet_cycles < QUIET_LIMIT);
    $display("%0t: no word moved for %0d cycles", $time, QUIET_LIMIT);
    $display("joystick_frame_differential_drive_top test failed");
    $finish;
  end

  initial begin : receiver
    int unsigned stretch;
    int unsigned pct;
    out_stall_i = 1'b0;
    stretch = 0;
    pct = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_req = 1'b0;
      end else begin
        if (stretch == 0) begin
          stretch = $urandom_range(16, 150);
          case ($urandom_range(0, 2))
            0: begin
              pct = 0;
            end
            1: begin
              pct = 30;
            end
            default: begin
              pct = 75;
            end
          endcase
        end
        stretch--;
        out_stall_i <= ($urandom_range(0, 99) < pct);
      end
    end
  end

  task automatic offer_word(input jfdd_pkg::in_word_t w, input logic typed,
                            input jfdd_pkg::out_word_t drive);
    @(negedge clk_i);
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_valid_i    <= 1'b1;
    in_word_i     <= w;
    in_typed      = typed;
    in_typed_word = drive;
    do @(posedge clk_i); while (in_stall_o);
    words_sent++;
  endtask

  task automatic offer_byte(input logic [7:0] b);
    offer_word({jfdd_pkg::REQ_BYTE, b}, 1'b0, NONE);
  endtask

  task automatic offer_tick();
    offer_word({jfdd_pkg::REQ_TICK, 8'($urandom_range(0, 255))}, 1'b0, NONE);
  endtask

  task automatic quiesce();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_drive.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      jfdd_pkg::REG_DEADBAND: begin
        m_deadband = value[6:0];
      end
      jfdd_pkg::REG_PERIOD: begin
        m_period = value[15:0];
      end
      jfdd_pkg::REG_CENTRE: begin
        m_centre = value[9:0];
      end
      default: begin
        m_timeout = value[15:0];
      end
    endcase
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic apply_setting(input int db, input int period, input int centre,
                               input int ticks);
    quiesce();
    write_reg(jfdd_pkg::REG_DEADBAND, db);
    write_reg(jfdd_pkg::REG_PERIOD, period);
    write_reg(jfdd_pkg::REG_CENTRE, centre);
    write_reg(jfdd_pkg::REG_TIMEOUT, ticks);
    settings_run++;
  endtask

  task automatic mixed_traffic(input int unsigned target);
    int unsigned sel;
    int unsigned n;
    while (words_sent < target) begin
      sel = $urandom_range(0, 99);
      if (sel < 70) begin
        for (int k = 0; k < FRAME_LEN; k++) begin
          if ($urandom_range(0, 99) < 10) offer_tick();
          if ($urandom_range(0, 99) < 8) offer_byte(8'($urandom_range(0, 255)));
          else offer_byte(jfdd_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)));
        end
      end else if (sel < 85) begin
        if (m_timeout != 0 && m_timeout <= 64) n = $urandom_range(1, m_timeout + 2);
        else n = $urandom_range(1, 8);
        repeat (n) offer_tick();
      end else begin
        repeat ($urandom_range(1, 5)) offer_byte(8'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    in_word_i     = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    in_typed      = 1'b0;
    in_typed_word = NONE;
    hold_req      = 1'b0;
    errors        = 0;
    frame_results = 0;
    stop_results  = 0;
    words_sent    = 0;
    burst_left    = 0;
    settings_run  = 1;
    quiet_cycles  = 0;
    m_deadband    = jfdd_pkg::DEADBAND_RST;
    m_period      = jfdd_pkg::PERIOD_RST;
    m_centre      = jfdd_pkg::CENTRE_RST;
    m_timeout     = jfdd_pkg::TIMEOUT_RST;
    m_index       = '0;
    m_idle        = '0;
    for (int i = 0; i < 8; i++) m_store[i] = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (DIR_ROWS[i]) offer_word(DIR_ROWS[i].word, DIR_ROWS[i].typed, DIR_ROWS[i].drive);

    apply_setting(0, 65535, 0, 1);
    mixed_traffic(words_sent + MIX_WORDS);

    apply_setting(127, 1, 999, 65535);
    hold_req = 1'b1;
    mixed_traffic(words_sent + MIX_WORDS);

    apply_setting(0, 0, 1023, 0);
    mixed_traffic(words_sent + MIX_WORDS);

    apply_setting($urandom_range(0, 127), $urandom_range(1, 65535), 500,
                  $urandom_range(4, 30));
    mixed_traffic(words_sent + MIX_WORDS);

    apply_setting($urandom_range(0, 127), $urandom_range(1, 65535), $urandom_range(0, 999),
                  $urandom_range(2, 12));
    mixed_traffic(words_sent + MIX_WORDS);

    quiesce();
    $display("Sent %0d input words under %0d register settings.", words_sent, settings_run);
    $display("Checked %0d frame drive words and %0d watchdog stops.", frame_results,
             stop_results);
    if (errors == 0) begin
      $display("joystick_frame_differential_drive_top test passed");
    end else begin
      $display("joystick_frame_differential_drive_top test failed");
    end
    $finish;
  end

endmodule
